// ----- rtl/ppts_pkg.sv -----
`timescale 1ns / 1ps
package ppts_pkg;

  localparam int unsigned MaxPointsDef = 1024;

  // 0.05 per metre in Q8.16, rounded to nearest
  localparam logic [23:0] KappaBias = 24'd3277;

  localparam logic [31:0] LaMinRst    = 32'd65536;
  localparam logic [23:0] LaGainRst   = 24'd32768;
  localparam logic [31:0] CapScaleRst = 32'd65536;
  localparam logic [10:0] PathLenRst  = 11'd1;

  localparam int unsigned CapW = 48;

  typedef enum logic [1:0] {
    REG_LA_MIN    = 2'd0,
    REG_LA_GAIN   = 2'd1,
    REG_CAP_SCALE = 2'd2,
    REG_PATH_LEN  = 2'd3
  } reg_idx_e;

endpackage

// ----- rtl/ppts_cap_unit.sv -----
`timescale 1ns / 1ps
module ppts_cap_unit import ppts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [23:0]       curvature_i,
  input  logic [31:0]       scale_i,
  output logic              done_o,
  output logic [CapW-1:0]   cap_o
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_ROOT = 4'b0010,
    C_DIV  = 4'b0100,
    C_DONE = 4'b1000
  } cstate_e;

  cstate_e state_q, state_d;

  logic [41:0] rad_q, rad_d, res_q, res_d, bit_q, bit_d;
  logic [20:0] rem_q, rem_d;
  logic [CapW-1:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;

  logic [23:0] kmag;
  logic [24:0] s_sum;
  logic [41:0] trial;
  logic [21:0] rem_sh;

  assign kmag   = curvature_i[23] ? (24'd0 - curvature_i) : curvature_i;
  assign s_sum  = {1'b0, kmag} + {1'b0, KappaBias};
  assign trial  = res_q + bit_q;
  assign rem_sh = {rem_q, quo_q[CapW-1]};

  always_comb begin
    state_d = state_q;
    rad_d   = rad_q;
    res_d   = res_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          rad_d   = {1'b0, s_sum, 16'd0};
          res_d   = '0;
          bit_d   = 42'd1 << 40;
          cnt_d   = 6'd20;
          state_d = C_ROOT;
        end
      end
      C_ROOT: begin
        // one root digit per cycle
        if (rad_q >= trial) begin
          rad_d = rad_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (cnt_q == 6'd0) begin
          rem_d   = '0;
          quo_d   = {scale_i, 16'd0};
          cnt_d   = 6'(CapW - 1);
          state_d = C_DIV;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      C_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem_sh >= {1'b0, res_q[20:0]}) begin
          rem_d = 21'(rem_sh - {1'b0, res_q[20:0]});
          quo_d = {quo_q[CapW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[20:0];
          quo_d = {quo_q[CapW-2:0], 1'b0};
        end
        if (cnt_q == 6'd0) state_d = C_DONE;
        else cnt_d = cnt_q - 6'd1;
      end
      C_DONE: begin
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    res_q <= res_d;
    bit_q <= bit_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = (state_q == C_DONE);
  assign cap_o  = quo_q;

endmodule

// ----- rtl/pure_pursuit_target_search_core.sv -----
`timescale 1ns / 1ps
// A load request is written to the path store in the cycle it is accepted.
// A query scans the points from the start index in turn; it uses the shared
// 33x33 multiplier, the root/divide unit and the single memory read port.
// One request at a time; a stalled result holds it.
// Reset: rst_ni async low clears control and config; path store is undefined.
module pure_pursuit_target_search_core import ppts_pkg::*; #(
  parameter int unsigned MAX_POINTS = MaxPointsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request stream
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  // tdata: point_index[9:0] point_x[41:10] point_y[73:42] robot_x[105:74]
  // robot_y[137:106] speed_ref[153:138] curvature[177:154] nearest_index[187:178]
  input  logic [191:0]  s_tdata_i,
  // tuser: kind[0]
  input  logic          s_tuser_i,
  // result stream
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  // tdata: target_index[9:0] target_x[41:10] target_y[73:42]
  output logic [79:0]   m_tdata_o,
  // configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_GAIN  = 12'b000000000010,
    S_SUM   = 12'b000000000100,
    S_CAP   = 12'b000000001000,
    S_LSQ   = 12'b000000010000,
    S_LSQ2  = 12'b000000100000,
    S_RD    = 12'b000001000000,
    S_SQX   = 12'b000010000000,
    S_SQY   = 12'b000100000000,
    S_CMP   = 12'b001000000000,
    S_LAST  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [31:0] la_min_q, cap_scale_q;
  logic [23:0] la_gain_q;
  logic [10:0] path_len_q;

  // query fields held for the whole search
  logic [31:0] rx_q, ry_q;
  logic [15:0] speed_q;
  logic [23:0] curv_q;
  logic [9:0]  near_q;

  logic [32:0] la_q, la_d;
  logic [65:0] lsq_q, sqx_q, prod_q;
  logic [AW-1:0] idx_q, idx_d, tgt_q, tgt_d;

  // path store and its registered read port
  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [31:0] rd_x_q, rd_y_q;
  logic        rd_en;
  logic [AW-1:0] rd_addr;

  logic        m_valid_q;
  logic [79:0] m_data_q;

  logic            cap_start;
  logic            cap_done;
  logic [CapW-1:0] cap_val;

  logic s_acc, cfg_wr;
  assign s_tready_o = (state_q == S_IDLE);
  assign s_acc      = s_tvalid_i & s_tready_o;
  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite & pready;

  // effective path length and scan bounds
  logic [31:0] cnt_eff, near_ext;
  logic [AW-1:0] last_idx, start_idx;
  always_comb begin
    if (path_len_q == 11'd0) cnt_eff = 32'd1;
    else if (32'(path_len_q) > 32'(MAX_POINTS)) cnt_eff = 32'(MAX_POINTS);
    else cnt_eff = 32'(path_len_q);
    last_idx  = AW'(cnt_eff - 32'd1);
    near_ext  = 32'(near_q);
    start_idx = (near_ext >= cnt_eff) ? last_idx : AW'(near_ext);
  end

  // absolute distances from the robot, 33 bits each
  logic [32:0] dx, dy, ax, ay;
  assign dx = {rd_x_q[31], rd_x_q} - {rx_q[31], rx_q};
  assign dy = {rd_y_q[31], rd_y_q} - {ry_q[31], ry_q};
  assign ax = dx[32] ? (33'd0 - dx) : dx;
  assign ay = dy[32] ? (33'd0 - dy) : dy;

  // shared multiplier, product registered every cycle
  logic [32:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_GAIN: begin
        mul_a = 33'(la_gain_q);
        mul_b = 33'(speed_q);
      end
      S_LSQ: begin
        mul_a = la_q;
        mul_b = la_q;
      end
      S_SQX: begin
        mul_a = ax;
        mul_b = ax;
      end
      S_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) prod_q <= mul_a * mul_b;

  logic [66:0] dist_sq;
  assign dist_sq = {1'b0, sqx_q} + {1'b0, prod_q};

  ppts_cap_unit u_cap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cap_start),
    .curvature_i (curv_q),
    .scale_i     (cap_scale_q),
    .done_o      (cap_done),
    .cap_o       (cap_val)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    la_d      = la_q;
    idx_d     = idx_q;
    tgt_d     = tgt_q;
    rd_en     = 1'b0;
    rd_addr   = idx_q;
    cap_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc && s_tuser_i) state_d = S_GAIN;
      end
      S_GAIN: state_d = S_SUM;
      S_SUM: begin
        // gain*speed is Q.24: drop 8 fraction bits
        la_d      = {1'b0, la_min_q} + 33'(prod_q[39:8]);
        cap_start = 1'b1;
        state_d   = S_CAP;
      end
      S_CAP: begin
        if (cap_done) begin
          if (CapW'(la_q) > cap_val) la_d = 33'(cap_val);
          state_d = S_LSQ;
        end
      end
      S_LSQ: state_d = S_LSQ2;
      S_LSQ2: begin
        idx_d   = start_idx;
        state_d = S_RD;
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_SQX;
      end
      S_SQX: state_d = S_SQY;
      S_SQY: state_d = S_CMP;
      S_CMP: begin
        if (dist_sq >= {1'b0, lsq_q}) begin
          // hit: read data is already the chosen point
          tgt_d   = idx_q;
          state_d = S_OUT;
        end else if (idx_q == last_idx) begin
          tgt_d   = last_idx;
          state_d = S_LAST;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_RD;
        end
      end
      S_LAST: begin
        rd_en   = 1'b1;
        rd_addr = last_idx;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!m_valid_q || m_tready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      m_valid_q   <= 1'b0;
      la_min_q    <= LaMinRst;
      la_gain_q   <= LaGainRst;
      cap_scale_q <= CapScaleRst;
      path_len_q  <= PathLenRst;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && (!m_valid_q || m_tready_i)) m_valid_q <= 1'b1;
      else if (m_tready_i) m_valid_q <= 1'b0;
      if (cfg_wr) begin
        unique case (reg_idx_e'(paddr[3:2]))
          REG_LA_MIN:    la_min_q    <= pwdata;
          REG_LA_GAIN:   la_gain_q   <= pwdata[23:0];
          REG_CAP_SCALE: cap_scale_q <= pwdata;
          REG_PATH_LEN:  path_len_q  <= pwdata[10:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    la_q  <= la_d;
    idx_q <= idx_d;
    tgt_q <= tgt_d;
    if (state_q == S_LSQ2) lsq_q <= prod_q;
    if (state_q == S_SQY) sqx_q <= prod_q;
    if (s_acc && s_tuser_i) begin
      rx_q    <= s_tdata_i[105:74];
      ry_q    <= s_tdata_i[137:106];
      speed_q <= s_tdata_i[153:138];
      curv_q  <= s_tdata_i[177:154];
      near_q  <= s_tdata_i[187:178];
    end
    if (state_q == S_OUT && (!m_valid_q || m_tready_i)) begin
      m_data_q <= {6'd0, rd_y_q, rd_x_q, 10'(tgt_q)};
    end
  end

  // store: write on load requests, drop slots past the end
  always_ff @(posedge clk_i) begin
    if (s_acc && !s_tuser_i && (32'(s_tdata_i[9:0]) < 32'(MAX_POINTS))) begin
      mem_x[AW'(s_tdata_i[9:0])] <= s_tdata_i[41:10];
      mem_y[AW'(s_tdata_i[9:0])] <= s_tdata_i[73:42];
    end
    if (rd_en) begin
      rd_x_q <= mem_x[rd_addr];
      rd_y_q <= mem_y[rd_addr];
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_LA_MIN:    prdata = la_min_q;
      REG_LA_GAIN:   prdata = 32'(la_gain_q);
      REG_CAP_SCALE: prdata = cap_scale_q;
      REG_PATH_LEN:  prdata = 32'(path_len_q);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- verif/tb_pure_pursuit_target_search_core.sv -----
`timescale 1ns / 1ps
// Testbench for pure_pursuit_target_search_core.
// Loads small paths through the request stream, then fires lookahead queries.
// A local predictor works out the target of each query from a private copy of
// the path store and the register settings, and a checker compares each result
// field by field with the oldest expected target. The registers go through
// several settings, the extremes among them, and both stream sides stall in
// random bursts.
module tb_pure_pursuit_target_search_core;
  import ppts_pkg::*;

  localparam int unsigned NumPoints = 1024;

  typedef struct {
    logic               is_query;
    logic [9:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic [15:0]        speed_ref;
    logic signed [23:0] curvature;
    logic [9:0]         nearest_index;
  } request_t;

  typedef struct {
    logic [9:0]  target_index;
    logic [31:0] target_x;
    logic [31:0] target_y;
  } target_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  // tdata: point_index, point_x, point_y, robot_x, robot_y, speed_ref,
  // curvature, nearest_index, zero fill
  logic [191:0] s_tdata_i = '0;
  // tuser: kind
  logic         s_tuser_i = 1'b0;
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  // tdata: target_index, target_x, target_y
  logic [79:0]  m_tdata_o;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Shadow copy of the block's registers and path store
  logic [31:0]  la_min_q = LaMinRst;
  logic [23:0]  la_gain_q = LaGainRst;
  logic [31:0]  cap_scale_q = CapScaleRst;
  logic [10:0]  path_len_q = PathLenRst;
  logic [31:0]  path_x_q [NumPoints];
  logic [31:0]  path_y_q [NumPoints];

  target_t      pending_targets[$];
  int unsigned  num_errors = 0;
  bit           idle_on = 1'b1;

  pure_pursuit_target_search_core DUT (.*);

  always #10 clk_i = ~clk_i;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
    num_errors++;
  endtask

  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [31:0] acc;
    logic [63:0] trial;
    acc = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = {32'b0, acc | (32'd1 << b)};
      if (trial * trial <= v) acc = acc | (32'd1 << b);
    end
    return acc;
  endfunction

  function automatic logic [63:0] abs_dist(input logic [31:0] p, input logic [31:0] r);
    longint d;
    d = longint'(signed'(p)) - longint'(signed'(r));
    return d < 0 ? -d : d;
  endfunction

  // Lookahead target for one query against the current path and settings
  function automatic target_t lookahead_target(input request_t q);
    logic [63:0]  la, cap, kmag, root;
    logic [127:0] ld_sq, dist_sq, dx, dy;
    int           count, first, pick;
    target_t      t;
    la = {32'b0, la_min_q} + (({40'b0, la_gain_q} * {48'b0, q.speed_ref}) >> 8);
    kmag = q.curvature < 0 ? -longint'(q.curvature) : longint'(q.curvature);
    root = {32'b0, floor_root((kmag + KappaBias) << 16)};
    cap = ({32'b0, cap_scale_q} << 16) / root;
    if (la > cap) la = cap;
    ld_sq = {64'b0, la};
    ld_sq = ld_sq * ld_sq;
    count = path_len_q == 0 ? 1 : (path_len_q > NumPoints ? NumPoints : path_len_q);
    first = q.nearest_index >= count ? count - 1 : q.nearest_index;
    pick = count - 1;
    for (int i = first; i < count; i++) begin
      dx = {64'b0, abs_dist(path_x_q[i], q.robot_x)};
      dy = {64'b0, abs_dist(path_y_q[i], q.robot_y)};
      dist_sq = dx * dx + dy * dy;
      if (dist_sq >= ld_sq) begin
        pick = i;
        break;
      end
    end
    t.target_index = pick[9:0];
    t.target_x = path_x_q[pick];
    t.target_y = path_y_q[pick];
    return t;
  endfunction

  // Drive one request, hold it until accepted, then update the shadow state
  task automatic send_request(input request_t q);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= q.is_query;
    s_tdata_i  <= {4'b0, q.nearest_index, q.curvature, q.speed_ref, q.robot_y,
                   q.robot_x, q.point_y, q.point_x, q.point_index};
    do @(posedge clk_i); while (!s_tready_o);
    if (q.is_query) begin
      pending_targets.push_back(lookahead_target(q));
    end else begin
      path_x_q[q.point_index] = q.point_x;
      path_y_q[q.point_index] = q.point_y;
    end
  endtask

  task automatic stop_sending();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold until all targets are back, then let any trailing load settle
  task automatic drain();
    stop_sending();
    while (pending_targets.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LA_MIN:    la_min_q = value;
      REG_LA_GAIN:   la_gain_q = value[23:0];
      REG_CAP_SCALE: cap_scale_q = value;
      REG_PATH_LEN:  path_len_q = value[10:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic request_t load_point(input int idx, input logic [31:0] x,
                                          input logic [31:0] y);
    request_t q;
    q = '{default: '0};
    q.point_index = idx[9:0];
    q.point_x = x;
    q.point_y = y;
    q.robot_x = $urandom;
    q.robot_y = $urandom;
    q.speed_ref = 16'($urandom);
    q.curvature = 24'($urandom);
    q.nearest_index = 10'($urandom);
    return q;
  endfunction

  function automatic request_t make_query(input logic [31:0] rx, input logic [31:0] ry,
                                          input logic [15:0] spd, input logic [23:0] kappa,
                                          input logic [9:0] near);
    request_t q;
    q = load_point($urandom_range(0, 1023), $urandom, $urandom);
    q.is_query = 1'b1;
    q.robot_x = rx;
    q.robot_y = ry;
    q.speed_ref = spd;
    q.curvature = kappa;
    q.nearest_index = near;
    return q;
  endfunction

  // Point within a few metres of a center, so lookahead comparisons go both ways
  function automatic logic [31:0] near_coord(input logic [31:0] center, input int span_m);
    return center + $urandom_range(0, span_m << 17) - (span_m << 16);
  endfunction

  // Load every slot up to count with points scattered around a center
  task automatic load_path(input int count, input logic [31:0] cx, input logic [31:0] cy,
                           input int span_m);
    for (int i = 0; i < count; i++)
      send_request(load_point(i, near_coord(cx, span_m), near_coord(cy, span_m)));
  endtask

  task automatic random_query(input logic [31:0] cx, input logic [31:0] cy);
    send_request(make_query(near_coord(cx, 4), near_coord(cy, 4),
                            16'($urandom_range(0, 3) == 0 ? $urandom
                                                          : $urandom_range(0, 1024)),
                            24'($urandom),
                            10'($urandom_range(0, 3) == 0 ? $urandom
                                                          : $urandom_range(0, 40))));
  endtask

  task automatic test_defaults();
    // Single-point path: every query answers with point zero
    send_request(load_point(0, 32'h8000_0000, 32'h7FFF_FFFF));
    send_request(make_query(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 24'h7FFFFF, 10'h3FF));
    send_request(make_query(32'h0, 32'h0, 16'h0, 24'h800000, 10'h0));
    drain();
  endtask

  task automatic test_directed();
    write_reg(REG_PATH_LEN, 32'd8);
    send_request(load_point(0, 32'h0, 32'h0));
    send_request(load_point(1, 32'h0001_0000, 32'h0));
    send_request(load_point(2, 32'h0002_0000, 32'h0));
    send_request(load_point(3, 32'h0003_0000, 32'hFFFF_0000));
    send_request(load_point(4, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_request(load_point(5, 32'h8000_0000, 32'h8000_0000));
    send_request(load_point(6, 32'hFFFF_FFFF, 32'h0));
    send_request(load_point(7, 32'h0, 32'h1));
    // Default lookahead reaches point 2 from the origin at speed 2 m/s
    send_request(make_query(32'h0, 32'h0, 16'h0200, 24'h0, 10'h0));
    // Tight curvature caps the lookahead hard
    send_request(make_query(32'h0, 32'h0, 16'hFFFF, 24'h7FFFFF, 10'h0));
    send_request(make_query(32'h0, 32'h0, 16'hFFFF, 24'h800000, 10'h1));
    // Nearest index past the end clamps to the last point
    send_request(make_query(32'h0, 32'h0, 16'h0, 24'h0, 10'h3FF));
    send_request(make_query(32'h8000_0000, 32'h8000_0000, 16'h0, 24'h0, 10'h5));
    drain();
    // Zero lookahead: the start point always qualifies
    write_reg(REG_LA_MIN, 32'h0);
    write_reg(REG_LA_GAIN, 32'h0);
    send_request(make_query(32'h0, 32'h0, 16'hFFFF, 24'h0, 10'h0));
    drain();
    // Huge lookahead with huge cap: nothing qualifies, last point answers
    write_reg(REG_LA_MIN, 32'hFFFF_FFFF);
    write_reg(REG_LA_GAIN, 32'hFF_FFFF);
    write_reg(REG_CAP_SCALE, 32'hFFFF_FFFF);
    send_request(make_query(32'h0, 32'h0, 16'hFFFF, 24'h0, 10'h0));
    send_request(make_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 24'h0, 10'h2));
    drain();
    write_reg(REG_CAP_SCALE, 32'h0);
    send_request(make_query(32'h0, 32'h0, 16'hFFFF, 24'h0, 10'h3));
    drain();
    // Path length zero acts as one point
    write_reg(REG_PATH_LEN, 32'd0);
    send_request(make_query(32'h0, 32'h0, 16'h0, 24'h0, 10'h7));
    drain();
  endtask

  task automatic test_full_path();
    write_reg(REG_LA_MIN, 32'h0004_0000);
    write_reg(REG_LA_GAIN, 32'h01_0000);
    write_reg(REG_CAP_SCALE, 32'h0010_0000);
    write_reg(REG_PATH_LEN, 32'd24);
    load_path(24, 32'h0, 32'h0, 3);
    for (int i = 0; i < 4; i++) random_query(32'h0, 32'h0);
    // Far robot: every point qualifies immediately; near the center the scan runs out
    send_request(make_query(32'h4000_0000, 32'h0, 16'h0, 24'h0, 10'h0));
    send_request(make_query(32'h0, 32'h0, 16'hFFFF, 24'h0, 10'h0));
    drain();
    // Over-range length acts as the full store; zero lookahead stops at the start
    write_reg(REG_LA_MIN, 32'h0);
    write_reg(REG_LA_GAIN, 32'h0);
    write_reg(REG_PATH_LEN, 32'd2047);
    send_request(load_point(1000, 32'h0012_3456, 32'hFFED_CBA9));
    send_request(load_point(1023, 32'h8000_0001, 32'h7FFF_FFFE));
    send_request(make_query(32'h0, 32'h0, 16'hFFFF, 24'h0, 10'd1000));
    send_request(make_query(32'h0, 32'h0, 16'h0, 24'h7FFFFF, 10'h3FF));
    drain();
  endtask

  task automatic test_random(input int rounds);
    logic [31:0] cx, cy;
    int          len;
    for (int r = 0; r < rounds; r++) begin
      len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : $urandom_range(2, 40);
      write_reg(REG_PATH_LEN, len);
      write_reg(REG_LA_MIN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5 << 16));
      write_reg(REG_LA_GAIN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2 << 16));
      write_reg(REG_CAP_SCALE, $urandom_range(0, 3) == 0 ? $urandom
                                                         : $urandom_range(0, 16 << 16));
      cx = $urandom;
      cy = $urandom;
      load_path(len, cx, cy, 6);
      for (int i = 0; i < 12; i++) begin
        // Occasional reload of a live slot between queries
        if ($urandom_range(0, 5) == 0)
          send_request(load_point($urandom_range(0, len - 1), near_coord(cx, 6),
                                  near_coord(cy, 6)));
        random_query(cx, cy);
      end
      drain();
    end
  endtask

  // Result side: stall in random bursts, check each accepted result
  initial begin
    @(posedge rst_ni);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    target_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_targets.size() == 0) begin
        report("unexpected target_index", 32'(m_tdata_o[9:0]), 32'h0);
      end else begin
        want = pending_targets.pop_front();
        if (m_tdata_o[9:0] !== want.target_index)
          report("target_index", 32'(m_tdata_o[9:0]), 32'(want.target_index));
        if (m_tdata_o[41:10] !== want.target_x)
          report("target_x", m_tdata_o[41:10], want.target_x);
        if (m_tdata_o[73:42] !== want.target_y)
          report("target_y", m_tdata_o[73:42], want.target_y);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);
    test_defaults();
    test_directed();
    test_full_path();
    test_random(12);
    // Last stretch at full rate on both sides
    idle_on = 1'b0;
    test_random(4);
    drain();
    if (num_errors == 0 && pending_targets.size() == 0) begin
      $display("pure_pursuit_target_search_core: match");
    end else begin
      $display("pure_pursuit_target_search_core: mismatch");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("pure_pursuit_target_search_core: mismatch");
    $finish;
  end

endmodule
